// ----- rtl/seat_pkg.sv -----
// ----------------------------------------------------------------------------
// seat_pkg: shared types and constants for the edge adjacency table
// Request and status codes, controller states, table entry layout and the
// slot update used when a segment end is stored.
// ----------------------------------------------------------------------------
package seat_pkg;

  localparam int CODE_W = 12;   // signed edge code
  localparam int CFG_W  = 11;   // num_edges register
  localparam int EP_W   = 12;   // endpoint field
  localparam int NB_W   = 11;   // neighbour field

  localparam logic [EP_W-1:0] EP_EMPTY = '1;   // -1
  localparam logic [NB_W-1:0] NB_EMPTY = '1;   // -1

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CODE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WR_A,
    S_RD_B,
    S_WR_B,
    S_CLEAR,
    S_DONE
  } state_t;

  // occ marks a first slot that holds a segment end
  typedef struct packed {
    logic            occ;
    logic [EP_W-1:0] ep0;
    logic [NB_W-1:0] nb0;
    logic [EP_W-1:0] ep1;
    logic [NB_W-1:0] nb1;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{occ: 1'b0, ep0: EP_EMPTY, nb0: NB_EMPTY,
                                     ep1: EP_EMPTY, nb1: NB_EMPTY};

  // controller -> datapath
  typedef struct packed {
    logic take_in;    // latch request
    logic decode;     // latch status and indices, read first edge
    logic wr_a;       // store first end
    logic rd_b;       // read the entry of edge b
    logic wr_b;       // store second end, bump segment count
    logic clr_start;  // zero counters for a clear
    logic clr_step;   // empty one entry
    logic load_out;   // move result to output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_t req;
    logic req_ok;     // status of the pending request is ok
    logic clr_none;   // no edges in use
    logic clr_last;   // sweep is at its last entry
    logic out_free;   // output register can take a result
  } stat_t;

  function automatic entry_t put_end(entry_t cur, logic [EP_W-1:0] ep,
                                     logic [NB_W-1:0] nb);
    entry_t res;
    res = cur;
    if (!cur.occ) begin
      res.occ = 1'b1;
      res.ep0 = ep;
      res.nb0 = nb;
    end else begin
      res.ep1 = ep;
      res.nb1 = nb;
    end
    return res;
  endfunction

endpackage

// ----- rtl/seat_ram.sv -----
// ----------------------------------------------------------------------------
// seat_ram: generic single write, single read RAM
// One write port, one read port with registered read data that holds while
// no read is issued.
// ----------------------------------------------------------------------------
module seat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/seat_ctrl.sv -----
// ----------------------------------------------------------------------------
// seat_ctrl: request sequencer
// Steps each request through decode, table read-modify-write or clear sweep,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module seat_ctrl
  import seat_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (stat.req)
          REQ_CLEAR: state_nxt = stat.clr_none ? S_DONE : S_CLEAR;
          REQ_ADD:   state_nxt = stat.req_ok ? S_WR_A : S_DONE;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_WR_A:  state_nxt = S_RD_B;
      S_RD_B:  state_nxt = S_WR_B;
      S_WR_B:  state_nxt = S_DONE;
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.take_in = in_valid;
      end
      S_DECODE: begin
        cmd.decode    = 1'b1;
        cmd.clr_start = (stat.req == REQ_CLEAR);
      end
      S_WR_A:  cmd.wr_a     = 1'b1;
      S_RD_B:  cmd.rd_b     = 1'b1;
      S_WR_B:  cmd.wr_b     = 1'b1;
      S_CLEAR: cmd.clr_step = 1'b1;
      S_DONE:  cmd.load_out = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/seat_dp.sv -----
// ----------------------------------------------------------------------------
// seat_dp: adjacency table datapath
// Request registers, code decode, segment counter, clear sweep index, the
// slot table RAM, the num_edges register and the output register.
// ----------------------------------------------------------------------------
module seat_dp
  import seat_pkg::*;
#(
  parameter int MAX_EDGES    = 1024,
  parameter int MAX_SEGMENTS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [1:0]               in_req_type,
  input  logic signed [CODE_W-1:0] in_edge_code_a,
  input  logic signed [CODE_W-1:0] in_edge_code_b,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic signed [EP_W-1:0]   out_first_endpoint,
  output logic signed [NB_W-1:0]   out_first_neighbor,
  output logic signed [EP_W-1:0]   out_second_endpoint,
  output logic signed [NB_W-1:0]   out_second_neighbor
);

  localparam int IDX_W  = $clog2(MAX_EDGES);
  localparam int SC_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int CMP_W  = ($clog2(MAX_EDGES + 1) > CODE_W) ? $clog2(MAX_EDGES + 1) : CODE_W;
  localparam int ENT_W  = $bits(entry_t);

  // request registers
  req_t              req_r;
  logic [CODE_W-1:0] code_a_r, code_b_r;
  logic [IDX_W-1:0]  ia_r, ib_r;
  status_t           status_r;
  logic [SC_W-1:0]   seg_cnt_r;
  logic [CMP_W-1:0]  clr_idx_r;
  logic [CFG_W-1:0]  num_edges_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [EP_W-1:0]   out_ep0_r, out_ep1_r;
  logic [NB_W-1:0]   out_nb0_r, out_nb1_r;

  // decode
  logic [CODE_W-1:0] mag_a, mag_b;
  logic              ok_a, ok_b, cnt_full;
  logic [IDX_W-1:0]  ia_nxt, ib_nxt;
  status_t           status_nxt;
  logic [CMP_W-1:0]  clr_idx_inc;

  // table
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;
  logic [ENT_W-1:0]  ram_rdata_raw;
  logic [EP_W-1:0]   ep_a, ep_b;

  assign mag_a = code_a_r[CODE_W-1] ? (CODE_W'(0) - code_a_r) : code_a_r;
  assign mag_b = code_b_r[CODE_W-1] ? (CODE_W'(0) - code_b_r) : code_b_r;

  assign ok_a = (mag_a != '0)
             && (CMP_W'(mag_a) <= CMP_W'(num_edges_r))
             && (CMP_W'(mag_a) <= CMP_W'(MAX_EDGES));
  assign ok_b = (mag_b != '0)
             && (CMP_W'(mag_b) <= CMP_W'(num_edges_r))
             && (CMP_W'(mag_b) <= CMP_W'(MAX_EDGES));

  assign ia_nxt   = IDX_W'(mag_a - CODE_W'(1));
  assign ib_nxt   = IDX_W'(mag_b - CODE_W'(1));
  assign cnt_full = (seg_cnt_r >= SC_W'(MAX_SEGMENTS));

  always_comb begin
    status_nxt = ST_OK;
    case (req_r)
      REQ_ADD: begin
        if (!ok_a || !ok_b) status_nxt = ST_BAD_CODE;
        else if (cnt_full)  status_nxt = ST_FULL;
      end
      REQ_READ: begin
        if (!ok_a) status_nxt = ST_BAD_CODE;
      end
      default: status_nxt = ST_OK;
    endcase
  end

  assign clr_idx_inc = clr_idx_r + CMP_W'(1);

  assign stat.req      = req_r;
  assign stat.req_ok   = (status_nxt == ST_OK);
  assign stat.clr_none = (num_edges_r == '0);
  assign stat.clr_last = (clr_idx_inc == CMP_W'(num_edges_r))
                      || (clr_idx_inc == CMP_W'(MAX_EDGES));
  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      req_r    <= req_t'(in_req_type);
      code_a_r <= in_edge_code_a;
      code_b_r <= in_edge_code_b;
    end
    if (cmd.decode) begin
      status_r <= status_nxt;
      ia_r     <= ia_nxt;
      ib_r     <= ib_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r   <= '0;
      clr_idx_r   <= '0;
      num_edges_r <= CFG_W'(1024);
    end else begin
      if (cfg_wr_en) num_edges_r <= cfg_wr_data;
      if (cmd.clr_start) begin
        seg_cnt_r <= '0;
        clr_idx_r <= '0;
      end else if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_inc;
      end
      if (cmd.wr_b) seg_cnt_r <= seg_cnt_r + SC_W'(1);
    end
  end

  // endpoint numbers 2j and 2j+1, kept to the field width
  assign ep_a = EP_W'({seg_cnt_r, 1'b0});
  assign ep_b = EP_W'({seg_cnt_r, 1'b1});

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ia_r;
    ram_wdata = ENTRY_EMPTY;
    if (cmd.wr_a) begin
      ram_we    = 1'b1;
      ram_wdata = put_end(ram_rdata, ep_a, NB_W'(ib_r));
    end else if (cmd.wr_b) begin
      ram_we    = 1'b1;
      ram_waddr = ib_r;
      ram_wdata = put_end(ram_rdata, ep_b, NB_W'(ia_r));
    end else if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r[IDX_W-1:0];
    end
  end

  assign ram_re    = cmd.decode || cmd.rd_b;
  assign ram_raddr = cmd.rd_b ? ib_r : ia_nxt;
  assign ram_rdata = entry_t'(ram_rdata_raw);

  seat_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_EDGES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      if (req_r == REQ_READ && status_r == ST_OK) begin
        out_ep0_r <= ram_rdata.ep0;
        out_nb0_r <= ram_rdata.nb0;
        out_ep1_r <= ram_rdata.ep1;
        out_nb1_r <= ram_rdata.nb1;
      end else begin
        out_ep0_r <= '0;
        out_nb0_r <= '0;
        out_ep1_r <= '0;
        out_nb1_r <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_first_endpoint  = out_ep0_r;
  assign out_first_neighbor  = out_nb0_r;
  assign out_second_endpoint = out_ep1_r;
  assign out_second_neighbor = out_nb1_r;

endmodule

// ----- rtl/segment_edge_adjacency_table_top.sv -----
// ----------------------------------------------------------------------------
// segment_edge_adjacency_table_top: per-edge segment adjacency table
// A read, error or no-op goes from decode to the result; an add writes its
// first end, then reads and writes the second; a clear sweeps the edges in use.
// One request at a time: the next is accepted in the cycle after the result
// reaches the output register.
// Reset clears the sequencer, segment counter and output valid and sets
// num_edges to 1024; the table contents are undefined until a clear request.
// ----------------------------------------------------------------------------
module segment_edge_adjacency_table_top
  import seat_pkg::*;
#(
  parameter int MAX_EDGES    = 1024,
  parameter int MAX_SEGMENTS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_req_type,
  input  logic signed [CODE_W-1:0] in_edge_code_a,
  input  logic signed [CODE_W-1:0] in_edge_code_b,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic signed [EP_W-1:0]   out_first_endpoint,
  output logic signed [NB_W-1:0]   out_first_neighbor,
  output logic signed [EP_W-1:0]   out_second_endpoint,
  output logic signed [NB_W-1:0]   out_second_neighbor,
  // num_edges register
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data
);

  // The controller only sequences; all storage and arithmetic sit in the
  // datapath. An add is a read-modify-write on each end's entry in turn, so a
  // segment whose two ends name the same edge sees its first end already
  // stored. The output register lets a finished result wait while the next
  // request is taken.
  cmd_t  cmd;
  stat_t stat;

  seat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  seat_dp #(
    .MAX_EDGES    (MAX_EDGES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_req_type         (in_req_type),
    .in_edge_code_a      (in_edge_code_a),
    .in_edge_code_b      (in_edge_code_b),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_first_endpoint  (out_first_endpoint),
    .out_first_neighbor  (out_first_neighbor),
    .out_second_endpoint (out_second_endpoint),
    .out_second_neighbor (out_second_neighbor)
  );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for segment_edge_adjacency_table_top
// Drives clear, add, read and no-op requests over the valid/stall request
// channel and predicts every result from a behavioural copy of the edge slot
// table, the segment counter and the num_edges register. Results are checked
// field by field in order. A directed opening covers code and edge-count
// corners, a short burst runs with no idling on either side, and random phases
// follow with varied edge counts, random idling on both sides and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import seat_pkg::*;

  localparam int EDGE_LIMIT   = 1024;   // MAX_EDGES of the block
  localparam int SEG_LIMIT    = 1024;   // MAX_SEGMENTS of the block
  localparam int ITEM_TARGET  = 700;    // requests over the whole run
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int IDLE_LIMIT   = 5000;   // cycles without any handshake
  localparam int MAX_GAP      = 13;

  // one result as seen on the output channel
  typedef struct {
    logic [1:0]            status;
    logic signed [EP_W-1:0] first_ep;
    logic signed [NB_W-1:0] first_nb;
    logic signed [EP_W-1:0] second_ep;
    logic signed [NB_W-1:0] second_nb;
  } adj_reply_t;

  // --------------------------------------------------------------------------
  // Behavioural copy of the table plus the queue of replies still owed.
  // An empty first slot is recognised by a negative endpoint, as in the block
  // every stored endpoint is 0 or above.
  // --------------------------------------------------------------------------
  class adjacency_tracker;
    int          end_point [EDGE_LIMIT][2];
    int          far_edge  [EDGE_LIMIT][2];
    int unsigned seg_count;
    logic [CFG_W-1:0] edge_count;
    adj_reply_t  owed_replies[$];
    int unsigned errors;

    function new();
      seg_count  = 0;
      edge_count = CFG_W'(EDGE_LIMIT);
      errors     = 0;
      foreach (end_point[i]) begin
        end_point[i][0] = 0; end_point[i][1] = 0;
        far_edge[i][0]  = 0; far_edge[i][1]  = 0;
      end
    endfunction

    // register values above the table size act as the table size
    function int unsigned edges_in_use();
      return (edge_count > EDGE_LIMIT) ? EDGE_LIMIT : edge_count;
    endfunction

    function void set_edge_count(input logic [CFG_W-1:0] n);
      edge_count = n;
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    function bit code_to_index(input logic signed [CODE_W-1:0] code,
                               output int unsigned idx);
      int v;
      int mag;
      v   = int'(code);
      mag = (v < 0) ? -v : v;
      idx = 0;
      if (mag == 0 || mag > int'(edges_in_use())) return 1'b0;
      idx = mag - 1;
      return 1'b1;
    endfunction

    function void store_end(input int unsigned e, input int ep, input int other);
      int s;
      s = (end_point[e][0] < 0) ? 0 : 1;
      end_point[e][s] = ep;
      far_edge[e][s]  = other;
    endfunction

    // works out the reply to an accepted request and updates the table
    function void note_request(input logic [1:0] req,
                               input logic signed [CODE_W-1:0] code_a,
                               input logic signed [CODE_W-1:0] code_b);
      adj_reply_t  r;
      int unsigned ia, ib;
      bit          ok_a, ok_b;
      r.status    = ST_OK;
      r.first_ep  = '0;
      r.first_nb  = '0;
      r.second_ep = '0;
      r.second_nb = '0;
      ok_a = code_to_index(code_a, ia);
      ok_b = code_to_index(code_b, ib);
      case (req)
        REQ_CLEAR: begin
          for (int e = 0; e < int'(edges_in_use()); e++) begin
            end_point[e][0] = -1; end_point[e][1] = -1;
            far_edge[e][0]  = -1; far_edge[e][1]  = -1;
          end
          seg_count = 0;
        end
        REQ_ADD: begin
          if (!ok_a || !ok_b) begin
            r.status = ST_BAD_CODE;
          end else if (seg_count >= SEG_LIMIT) begin
            r.status = ST_FULL;
          end else begin
            store_end(ia, 2 * seg_count, ib);
            store_end(ib, 2 * seg_count + 1, ia);
            seg_count++;
          end
        end
        REQ_READ: begin
          if (!ok_a) begin
            r.status = ST_BAD_CODE;
          end else begin
            r.first_ep  = EP_W'(end_point[ia][0]);
            r.first_nb  = NB_W'(far_edge[ia][0]);
            r.second_ep = EP_W'(end_point[ia][1]);
            r.second_nb = NB_W'(far_edge[ia][1]);
          end
        end
        default: ;   // no-op, status ok
      endcase
      owed_replies.push_back(r);
    endfunction

    function void compare_field(input string name, input int want, input int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input adj_reply_t got);
      adj_reply_t want;
      if (owed_replies.size() == 0) begin
        $error("result with no request outstanding (status %0d)", got.status);
        errors++;
        return;
      end
      want = owed_replies.pop_front();
      compare_field("status",          int'(want.status),    int'(got.status));
      compare_field("first_endpoint",  int'(want.first_ep),  int'(got.first_ep));
      compare_field("first_neighbor",  int'(want.first_nb),  int'(got.first_nb));
      compare_field("second_endpoint", int'(want.second_ep), int'(got.second_ep));
      compare_field("second_neighbor", int'(want.second_nb), int'(got.second_nb));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT connections; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_req_type = REQ_NOP;
  logic signed [CODE_W-1:0] in_edge_code_a = '0;
  logic signed [CODE_W-1:0] in_edge_code_b = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               out_status;
  logic signed [EP_W-1:0]   out_first_endpoint;
  logic signed [NB_W-1:0]   out_first_neighbor;
  logic signed [EP_W-1:0]   out_second_endpoint;
  logic signed [NB_W-1:0]   out_second_neighbor;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]         cfg_wr_data = '0;

  adjacency_tracker tracker = new();

  // state for the sender, receiver, watchdog and main sequence
  bit          no_idle   = 1'b0;   // both sides run without gaps
  bit          long_hold = 1'b0;   // receiver takes one long hold-off
  int unsigned items_sent = 0;
  int unsigned idle_count = 0;

  segment_edge_adjacency_table_top #(
    .MAX_EDGES    (EDGE_LIMIT),
    .MAX_SEGMENTS (SEG_LIMIT)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_edge_code_a      (in_edge_code_a),
    .in_edge_code_b      (in_edge_code_b),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_first_endpoint  (out_first_endpoint),
    .out_first_neighbor  (out_first_neighbor),
    .out_second_endpoint (out_second_endpoint),
    .out_second_neighbor (out_second_neighbor),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  // 10 unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sender side. Payload and valid move on the falling edge; acceptance is
  // seen at the rising edge from the stall value before that edge.
  // --------------------------------------------------------------------------
  task automatic send_req(input req_t r, input logic signed [CODE_W-1:0] code_a,
                          input logic signed [CODE_W-1:0] code_b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid       = 1'b1;
    in_req_type    = r;
    in_edge_code_a = code_a;
    in_edge_code_b = code_b;
    do @(posedge clk); while (in_stall);
    tracker.note_request(r, code_a, code_b);
    items_sent++;
  endtask

  // drop valid and wait until every owed reply has come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // num_edges is only written with the block idle
  task automatic write_edge_count(input logic [CFG_W-1:0] n);
    drain();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = n;
    tracker.set_edge_count(n);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // random code: good ones index an edge in use, bad ones are zero or past
  // the edge count (only zero is left when every edge is in use)
  function automatic logic signed [CODE_W-1:0] pick_code(input bit good);
    int unsigned n;
    int unsigned mag;
    logic signed [CODE_W-1:0] c;
    n = tracker.edges_in_use();
    if (good && n > 0)
      mag = $urandom_range(1, n);
    else if (n >= EDGE_LIMIT || $urandom_range(0, 3) == 0)
      mag = 0;
    else
      mag = $urandom_range(n + 1, EDGE_LIMIT);
    c = CODE_W'(mag);
    if ($urandom_range(0, 1) == 1) c = -c;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: a random stall before each result, plus one long hold-off
  // while the sender keeps offering requests.
  // --------------------------------------------------------------------------
  initial begin
    adj_reply_t got;
    int gap;
    wait (rst_n);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        @(negedge clk);
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      got.status    = out_status;
      got.first_ep  = out_first_endpoint;
      got.first_nb  = out_first_neighbor;
      got.second_ep = out_second_endpoint;
      got.second_nb = out_second_neighbor;
      tracker.check_result(got);
    end
  end

  // watchdog: too long without any handshake on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_count <= 0;
      else
        idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("** segment_edge_adjacency_table_top: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_no;
    int unsigned len;
    int unsigned pick;
    bit          bad_a;
    logic [CFG_W-1:0] n;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // --- directed: full table first, so every entry is defined from here on
    write_edge_count(CFG_W'(EDGE_LIMIT));
    send_req(REQ_CLEAR, 12'sd0, 12'sd0);
    send_req(REQ_READ,  12'sd1, 12'sd0);          // empty slots read as -1
    send_req(REQ_READ,  -12'sd1024, 12'sd5);
    send_req(REQ_READ,  12'sd0, 12'sd1);          // zero code
    send_req(REQ_ADD,   12'sd1, -12'sd1024);      // lowest and highest edge
    send_req(REQ_ADD,   12'sd1024, -12'sd1);      // second slots now
    send_req(REQ_ADD,   12'sd5, 12'sd5);          // same edge at both ends
    send_req(REQ_ADD,   12'sd0, 12'sd3);          // bad code on either end
    send_req(REQ_ADD,   -12'sd3, 12'sd0);
    send_req(REQ_ADD,   12'sd2, 12'sd3);
    send_req(REQ_ADD,   12'sd2, 12'sd4);          // second slot filled, overwritten next
    send_req(REQ_ADD,   -12'sd2, 12'sd6);
    send_req(REQ_READ,  12'sd1, 12'sd0);
    send_req(REQ_READ,  12'sd1024, 12'sd0);
    send_req(REQ_READ,  -12'sd5, 12'sd0);
    send_req(REQ_READ,  12'sd2, 12'sd0);
    send_req(REQ_NOP,   -12'sd1024, 12'sd1024);   // unused request type

    // single edge in use: codes past it are bad
    write_edge_count(CFG_W'(1));
    send_req(REQ_CLEAR, 12'sd7, -12'sd7);
    send_req(REQ_ADD,   12'sd1, -12'sd1);
    send_req(REQ_READ,  -12'sd1, 12'sd0);
    send_req(REQ_READ,  12'sd2, 12'sd0);
    send_req(REQ_ADD,   12'sd1, 12'sd2);

    // zero edges: every code bad, clear only resets the counter
    write_edge_count(CFG_W'(0));
    send_req(REQ_READ,  12'sd1, 12'sd0);
    send_req(REQ_ADD,   12'sd1, 12'sd1);
    send_req(REQ_CLEAR, 12'sd0, 12'sd0);

    // oversized count acts as the table size; top edge keeps older contents
    write_edge_count('1);
    send_req(REQ_READ,  12'sd1024, 12'sd0);
    send_req(REQ_ADD,   12'sd1024, -12'sd1024);
    send_req(REQ_READ,  -12'sd1024, 12'sd0);
    send_req(REQ_READ,  12'sd2047, 12'sd0);       // codes past the table
    send_req(REQ_ADD,   12'sh800, 12'sd1);

    // --- back-to-back requests with no idling on either side
    write_edge_count(CFG_W'(EDGE_LIMIT));
    no_idle = 1'b1;
    send_req(REQ_CLEAR, 12'sd0, 12'sd0);
    repeat (16) send_req(REQ_ADD, pick_code(1'b1), pick_code(1'b1));
    send_req(REQ_ADD,  12'sd0, pick_code(1'b1));
    send_req(REQ_READ, pick_code(1'b1), pick_code(1'b1));
    send_req(REQ_READ, pick_code(1'b1), pick_code(1'b1));
    no_idle = 1'b0;

    // --- random phases, each with its own edge count
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       n = CFG_W'(1);
        1:       n = CFG_W'(2);
        2, 3:    n = CFG_W'(EDGE_LIMIT);
        4, 5, 6: n = CFG_W'($urandom_range(3, 16));
        default: n = CFG_W'($urandom_range(17, EDGE_LIMIT - 1));
      endcase
      write_edge_count(n);   // sender waits here for every reply
      no_idle = ($urandom_range(0, 3) == 0);
      // back-pressure: block fills and stalls its input during the hold
      if (phase_no == 1) long_hold = 1'b1;
      if ($urandom_range(0, 4) != 0)
        send_req(REQ_CLEAR, pick_code(1'($urandom_range(0, 1))),
                 pick_code(1'($urandom_range(0, 1))));
      len = $urandom_range(30, 90);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_req(REQ_ADD, pick_code(1'b1), pick_code(1'b1));
        end else if (pick < 83) begin
          send_req(REQ_READ, pick_code(1'b1), pick_code(1'($urandom_range(0, 1))));
        end else if (pick < 89) begin
          bad_a = 1'($urandom_range(0, 1));
          send_req(REQ_ADD, pick_code(!bad_a),
                   pick_code(bad_a && ($urandom_range(0, 1) == 1)));
        end else if (pick < 94) begin
          send_req(REQ_READ, pick_code(1'b0), pick_code(1'($urandom_range(0, 1))));
        end else if (pick < 97) begin
          send_req(REQ_CLEAR, pick_code(1'b1), pick_code(1'b0));
        end else begin
          send_req(REQ_NOP, pick_code(1'($urandom_range(0, 1))), pick_code(1'b1));
        end
      end
      phase_no++;
    end

    // --- wind down: all replies in, then a short quiet spell
    drain();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("** segment_edge_adjacency_table_top: PASSED **");
    end else begin
      $display("** segment_edge_adjacency_table_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/seat_pkg.sv
rtl/seat_ram.sv
rtl/seat_ctrl.sv
rtl/seat_dp.sv
rtl/segment_edge_adjacency_table_top.sv
tb/testbench.sv
